// ===== sv/key_offset_table_defines.svh =====
// Assertion macros shared by the key offset table RTL.
// Needs no other file; the macros expand to nothing when SYNTH is defined.
`ifndef KEY_OFFSET_TABLE_DEFINES_SVH
`define KEY_OFFSET_TABLE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define KOT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key_offset_table assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define KOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key_offset_table assertion failed");
`else
`define KOT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KOT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/kot_pkg.sv =====
// Shared types and codes for the key offset table.
// Depends on nothing; kot_store, kot_ctrl and key_offset_table import it.
package kot_pkg;

  localparam int KEY_W = 32;
  localparam int OFF_W = 32;

  // Request codes carried in req_type.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_SET    = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] new_offset;
  } kot_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset_out;
    logic             hit;
    logic             table_full;
  } kot_res_t;

  // Memory strobes from the sequencer to the storage.
  typedef struct packed {
    logic key_rd;
    logic off_rd;
    logic key_wr;
    logic off_wr;
  } kot_mem_ctl_t;

endpackage

// ===== sv/kot_if.sv =====
// Request and result channel interfaces for the key offset table.
// Depends on nothing but the field widths of the request and result items.
interface kot_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] key;
  logic [31:0] new_offset;

  modport source (output valid, output req_type, output key, output new_offset,
                  input ready);
  modport sink   (input valid, input req_type, input key, input new_offset,
                  output ready);
endinterface

interface kot_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] offset_out;
  logic        hit;
  logic        table_full;

  modport source (output valid, output offset_out, output hit, output table_full,
                  input ready);
  modport sink   (input valid, input offset_out, input hit, input table_full,
                  output ready);
endinterface

// ===== sv/kot_store.sv =====
// Key and offset memories of the key offset table, with registered read data.
// Depends on kot_pkg for the strobe struct.
module kot_store #(
  parameter int ENTRIES = 32,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                      clk,
  input  kot_pkg::kot_mem_ctl_t     ctl,
  input  logic [IDX_W-1:0]          addr,
  input  logic [kot_pkg::KEY_W-1:0] wr_key,
  input  logic [kot_pkg::OFF_W-1:0] wr_off,
  output logic [kot_pkg::KEY_W-1:0] key_rdata,
  output logic [kot_pkg::OFF_W-1:0] off_rdata
);
  import kot_pkg::*;

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [OFF_W-1:0] off_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.key_wr) begin
      key_mem[addr] <= wr_key;
    end
    if (ctl.key_rd) begin
      key_rdata <= key_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.off_wr) begin
      off_mem[addr] <= wr_off;
    end
    if (ctl.off_rd) begin
      off_rdata <= off_mem[addr];
    end
  end

endmodule

// ===== sv/kot_ctrl.sv =====
// Sequencer of the key offset table: scan, update or append, result register.
// Depends on kot_pkg, the channel interfaces and key_offset_table_defines.svh.
`include "key_offset_table_defines.svh"

module kot_ctrl #(
  parameter int ENTRIES = 32,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  kot_in_if.sink                    in_ch,
  kot_out_if.source                 out_ch,
  output kot_pkg::kot_mem_ctl_t     mem_ctl,
  output logic [IDX_W-1:0]          mem_addr,
  output logic [kot_pkg::KEY_W-1:0] wr_key,
  output logic [kot_pkg::OFF_W-1:0] wr_off,
  input  logic [kot_pkg::KEY_W-1:0] key_rdata,
  input  logic [kot_pkg::OFF_W-1:0] off_rdata
);
  import kot_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OFF_WAIT,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  kot_req_t         req_r, req_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  kot_res_t         res_r, res_nxt;
  logic             out_vld_r, out_vld_nxt;
  kot_res_t         out_res_r, out_res_nxt;

  logic match;
  logic more;
  logic room;

  // The key registered by the last scan read is compared against the request key.
  assign match = cmp_vld_r && (key_rdata == req_r.key);
  assign more  = scan_idx_r < fill_r;
  assign room  = fill_r < CNT_W'(ENTRIES);

  assign wr_key = req_r.key;
  assign wr_off = req_r.new_offset;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_vld_r;
  assign out_ch.offset_out = out_res_r.offset_out;
  assign out_ch.hit        = out_res_r.hit;
  assign out_ch.table_full = out_res_r.table_full;

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    fill_nxt     = fill_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    mem_ctl      = '0;
    mem_addr     = scan_idx_r[IDX_W-1:0];

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt.req_type   = in_ch.req_type;
          req_nxt.key        = in_ch.key;
          req_nxt.new_offset = in_ch.new_offset;
          scan_idx_nxt       = '0;
          cmp_vld_nxt        = 1'b0;
          state_nxt          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          mem_addr    = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          if (req_r.req_type == REQ_LOOKUP) begin
            mem_ctl.off_rd = 1'b1;
            state_nxt      = ST_OFF_WAIT;
          end else begin
            mem_ctl.off_wr = 1'b1;
            res_nxt        = '{offset_out: '0, hit: 1'b1, table_full: 1'b0};
            state_nxt      = ST_DONE;
          end
        end else if (more) begin
          mem_ctl.key_rd = 1'b1;
          cmp_idx_nxt    = scan_idx_r[IDX_W-1:0];
          cmp_vld_nxt    = 1'b1;
          scan_idx_nxt   = scan_idx_r + 1'b1;
        end else begin
          // No filled entry holds the key.
          cmp_vld_nxt = 1'b0;
          mem_addr    = fill_r[IDX_W-1:0];
          res_nxt     = '{offset_out: '0, hit: 1'b0, table_full: 1'b0};
          if (req_r.req_type == REQ_SET) begin
            if (room) begin
              mem_ctl.key_wr = 1'b1;
              mem_ctl.off_wr = 1'b1;
              fill_nxt       = fill_r + 1'b1;
            end else begin
              res_nxt.table_full = 1'b1;
            end
          end
          state_nxt = ST_DONE;
        end
      end
      ST_OFF_WAIT: begin
        res_nxt   = '{offset_out: off_rdata, hit: 1'b1, table_full: 1'b0};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_res_nxt = res_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    scan_idx_r  <= scan_idx_nxt;
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      fill_r    <= fill_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  `KOT_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(ENTRIES))
  `KOT_ASSERT_NEXT(a_fill_step, clk, rst_n, mem_ctl.key_wr, fill_r == CNT_W'($past(fill_r) + 1'b1))
  `KOT_ASSERT_NOW(a_append_is_set, clk, rst_n, mem_ctl.key_wr, req_r.req_type == REQ_SET && !match)
  `KOT_ASSERT_NOW(a_full_flag, clk, rst_n, out_vld_r && out_res_r.table_full, fill_r == CNT_W'(ENTRIES) && !out_res_r.hit)
  `KOT_ASSERT_NOW(a_scan_in_range, clk, rst_n, mem_ctl.key_rd, scan_idx_r < fill_r)

endmodule

// ===== sv/key_offset_table.sv =====
// Top level of the key offset table: storage plus sequencer.
// Depends on kot_pkg, kot_if, kot_store and kot_ctrl.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      req_type, key, new_offset
//   out_ch   out  valid / ready      offset_out, hit, table_full
//
// A miss scans every filled entry before its result stands in the output
// register: one entry is read per cycle and compared in the next cycle. A
// hit on an entry stops the scan early; a set then writes the new offset in
// place, while a lookup first reads the offset from the storage.
// Reset (rst_n low, synchronous) empties the table by clearing the fill count;
// the memories themselves are not cleared and need no sweep.
// The output register frees the input side: a new transaction is taken while
// a result still waits, and only the hand-over of the next result stalls.
module key_offset_table #(
  parameter int ENTRIES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  kot_in_if.sink     in_ch,
  kot_out_if.source  out_ch
);
  import kot_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Strobes, shared address and data between the sequencer and the memories.
  // Only one of scan read, offset read or write happens in a cycle, so the
  // sequencer itself keeps accesses to one entry from overlapping.
  kot_mem_ctl_t     mem_ctl;
  logic [IDX_W-1:0] mem_addr;
  logic [KEY_W-1:0] wr_key;
  logic [OFF_W-1:0] wr_off;
  logic [KEY_W-1:0] key_rdata;
  logic [OFF_W-1:0] off_rdata;

  // The sequencer scans the filled entries in insertion order, then reads the
  // offset, updates it in place or appends a new pair at the fill count if there is room.
  kot_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .wr_key    (wr_key),
    .wr_off    (wr_off),
    .key_rdata (key_rdata),
    .off_rdata (off_rdata)
  );

  // Key and offset memories with registered read data.
  kot_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .addr      (mem_addr),
    .wr_key    (wr_key),
    .wr_off    (wr_off),
    .key_rdata (key_rdata),
    .off_rdata (off_rdata)
  );

endmodule

// ===== tb/sv/key_offset_table_checker.sv =====
// Scoreboard for the key offset table: watches both channels, predicts every result.
// Depends on kot_pkg for the item types and request codes, and on kot_if for the channels.
module key_offset_table_checker #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst_n,
  kot_in_if    req_ch,
  kot_out_if   res_ch,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import kot_pkg::*;

  logic [KEY_W-1:0] table_keys    [ENTRIES];
  logic [OFF_W-1:0] table_offsets [ENTRIES];
  int               entries_used = 0;
  kot_res_t         pending_results [$];
  int               errors = 0;

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic kot_res_t apply_request(kot_req_t r);
    kot_res_t res;
    int       pos;
    res = '0;
    pos = -1;
    for (int i = 0; i < entries_used; i++) begin
      if (pos < 0 && table_keys[i] == r.key) pos = i;
    end
    if (r.req_type == REQ_LOOKUP) begin
      if (pos >= 0) begin
        res.offset_out = table_offsets[pos];
        res.hit        = 1'b1;
      end
    end else if (pos >= 0) begin
      table_offsets[pos] = r.new_offset;
      res.hit            = 1'b1;
    end else if (entries_used < ENTRIES) begin
      table_keys[entries_used]    = r.key;
      table_offsets[entries_used] = r.new_offset;
      entries_used++;
    end else begin
      res.table_full = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    kot_req_t req;
    kot_res_t want;
    if (!rst_n) begin
      entries_used = 0;
      pending_results.delete();
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        req.req_type   = req_ch.req_type;
        req.key        = req_ch.key;
        req.new_offset = req_ch.new_offset;
        pending_results.push_back(apply_request(req));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction arrived with no request outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (res_ch.offset_out !== want.offset_out) begin
            $error("offset_out mismatch: expected %h, actual %h",
                   want.offset_out, res_ch.offset_out);
            errors++;
          end
          if (res_ch.hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, res_ch.hit);
            errors++;
          end
          if (res_ch.table_full !== want.table_full) begin
            $error("table_full mismatch: expected %0d, actual %0d",
                   want.table_full, res_ch.table_full);
            errors++;
          end
        end
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= errors;
  end

endmodule

// ===== tb/sv/key_offset_table_test.sv =====
// Top of the key offset table testbench: clock, reset, request stimulus and result sink.
// Depends on kot_pkg, kot_if, the key_offset_table RTL and key_offset_table_checker.
module key_offset_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kot_pkg::*;

  localparam int TABLE_ENTRIES = 32;
  localparam int RANDOM_ITEMS  = 1630;
  // The slowest accepted transaction is a scan of the whole table plus the
  // longest gap on either side, so a long silence can only mean a hang.
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 50;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;

  kot_in_if  in_ch ();
  kot_out_if out_ch ();

  // Keys the stimulus has placed in the table, used to aim hits and near misses.
  logic [KEY_W-1:0] written_keys [$];
  bit               send_quiet;
  bit               recv_quiet;
  int               sent_count;

  key_offset_table #(
    .ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_offset_table_checker #(
    .ENTRIES(TABLE_ENTRIES)
  ) scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ch      (in_ch),
    .res_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit key_written(logic [KEY_W-1:0] k);
    foreach (written_keys[i]) begin
      if (written_keys[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // A key that is already in the table, or a fresh random one while it is empty.
  function automatic logic [KEY_W-1:0] stored_key();
    if (written_keys.size() == 0) return $urandom;
    return written_keys[$urandom_range(0, written_keys.size() - 1)];
  endfunction

  // Offsets lean toward the all-zero and all-one patterns now and then.
  function automatic logic [OFF_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Presents one request transaction after a random gap and waits until the
  // block takes it. With no gap, valid simply stays high from the previous
  // transaction, so it gets only one assignment in that time step.
  task automatic issue(logic req, logic [KEY_W-1:0] k, logic [OFF_W-1:0] off);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.key        <= k;
    in_ch.new_offset <= off;
    do @(posedge clk); while (!in_ch.ready);
    if (req == REQ_SET && !key_written(k) && written_keys.size() < TABLE_ENTRIES) begin
      written_keys.push_back(k);
    end
    sent_count++;
    // Every hundred transactions the sender may switch into a stretch with no gaps.
    if (sent_count % 100 == 0) send_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Drops valid and holds the sender off until the scoreboard has seen every
  // result it is waiting for. The first edge is always taken, so that the
  // count already includes the transaction accepted in this time step.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: a random stall before each result, with occasional
  // stretches where ready stays high throughout.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken % 64 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // The run is declared hung when neither channel moves a transaction
  // before the idle counter reaches IDLE_LIMIT.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_LOOKUP;
    in_ch.key        <= '0;
    in_ch.new_offset <= '0;
    rst_n            <= 1'b0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    sent_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Lookups on the empty table must miss, including the
    // all-zero key that the unwritten storage may well hold.
    issue(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    // Appends with the extreme keys and offsets, then lookup hits on them.
    issue(REQ_SET,    32'h0000_0000, 32'hFFFF_FFFF);
    issue(REQ_SET,    32'hFFFF_FFFF, 32'h0000_0000);
    issue(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // A set of a present key overwrites it in place; no second entry appears.
    issue(REQ_SET,    32'h0000_0000, 32'h1234_5678);
    issue(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    // Keys one bit away from stored keys must miss.
    issue(REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    issue(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    issue(REQ_SET,    32'h8000_0000, 32'h5555_5555);
    issue(REQ_SET,    32'h7FFF_FFFF, 32'hAAAA_AAAA);
    issue(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    issue(REQ_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
    issue(REQ_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Random part. Most transactions aim at stored keys so that hits and
    // updates dominate; new keys arrive slowly enough that the table fills
    // over the first few hundred transactions, and sets of new keys after
    // that exercise the refused, table-full case.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        issue(REQ_LOOKUP, stored_key(), $urandom);
      end else if (pick < 52) begin
        issue(REQ_SET, stored_key(), pick_offset());
      end else if (pick < 58) begin
        issue(REQ_SET, $urandom, pick_offset());
      end else if (pick < 61) begin
        k = stored_key() ^ (32'h1 << $urandom_range(0, 31));
        issue(REQ_SET, k, pick_offset());
      end else if (pick < 78) begin
        k = stored_key() ^ (32'h1 << $urandom_range(0, 31));
        issue(REQ_LOOKUP, k, $urandom);
      end else if (pick < 90) begin
        issue(REQ_LOOKUP, $urandom, $urandom);
      end else if (pick < 95) begin
        issue(REQ_LOOKUP, ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF, $urandom);
      end else begin
        issue(REQ_SET, ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF, pick_offset());
      end
      // Halfway through, the sender holds off once until all results are in.
      if (n == RANDOM_ITEMS / 2) wait_drained();
    end

    // Let every result come out, then give the block time to show any
    // stray transaction before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/kot_pkg.sv
sv/kot_if.sv
sv/kot_store.sv
sv/kot_ctrl.sv
sv/key_offset_table.sv
tb/sv/key_offset_table_checker.sv
tb/sv/key_offset_table_test.sv
